>>> sv/josephus_survivor_macros.svh
// assertion macros used by josephus_survivor
// each check is clocked on clk and disabled while rst_n is low
`ifndef JOSEPHUS_SURVIVOR_MACROS_SVH
`define JOSEPHUS_SURVIVOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define JS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JS_ASSERT_IMP(lbl, ante, cons, msg)
`define JS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/jsurv_pkg.sv
`default_nettype none

package jsurv_pkg;

    // default sizing
    localparam int MAX_PEOPLE = 256;
    localparam int TAG_BITS   = 16;

    // skip register
    localparam int SKIP_W = 10;
    localparam logic [SKIP_W-1:0] SKIP_RESET = 10'd1;

    // op codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

endpackage

`default_nettype wire

>>> sv/jsurv_ram.sv
`default_nettype none

module jsurv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/josephus_survivor.sv
`default_nettype none

// Josephus elimination engine. Add beats (op = 0) append a tag to the ring,
// writing the tag memory and the successor link at once; adds beyond
// MAX_PEOPLE are dropped and flagged. A run beat (op = 1) closes the ring
// and walks it through the link memory, one link per cycle on its single
// read port, with skip_count 0 acting as 1; a run on an empty ring loads
// the output register in the cycle after its beat. No input beat is taken
// while a run walks. The result sits in an output register, and no input
// beat is taken while it waits unless it leaves in the same cycle.
// skip_count is written through the cfg channel and must only change while
// the block is idle.

`include "josephus_survivor_macros.svh"

module josephus_survivor #(
    parameter int MAX_PEOPLE = jsurv_pkg::MAX_PEOPLE,
    parameter int TAG_BITS   = jsurv_pkg::TAG_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [jsurv_pkg::SKIP_W-1:0]  cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [TAG_BITS-1:0]           person_tag,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [TAG_BITS-1:0]           survivor_tag,
    output logic                               empty_game,
    output logic                               overflowed
);

    localparam int ADDR_W = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int CNT_W  = $clog2(MAX_PEOPLE + 1);
    localparam int SKIP_W = jsurv_pkg::SKIP_W;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEOPLE);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLOSE = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    // control registers
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [SKIP_W-1:0] steps_reg, steps_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [ADDR_W-1:0]   prev_reg, prev_next;
    logic [TAG_BITS-1:0] tag_out_reg, tag_out_next;
    logic                empty_out_reg, empty_out_next;
    logic                ovf_out_reg, ovf_out_next;

    // memory ports
    logic                link_we;
    logic [ADDR_W-1:0]   link_waddr, link_wdata, link_raddr, link_rdata;
    logic                tag_we;
    logic [ADDR_W-1:0]   tag_waddr, tag_raddr;
    logic [TAG_BITS-1:0] tag_rdata;

    logic                in_fire;
    logic [SKIP_W-1:0]   k_eff;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    cnt_dec;

    // successor links and tags
    jsurv_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_PEOPLE)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    jsurv_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (MAX_PEOPLE)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (person_tag),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // handshakes
    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign survivor_tag = tag_out_reg;
    assign empty_game   = empty_out_reg;
    assign overflowed   = ovf_out_reg;

    // skip of zero acts as one
    assign k_eff   = (skip_reg == '0) ? SKIP_W'(1) : skip_reg;
    assign cnt_inc = cnt_reg + CNT_ONE;
    assign cnt_dec = cnt_reg - CNT_ONE;

    // next-state and memory control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        remain_next    = remain_reg;
        steps_next     = steps_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        tag_out_next   = tag_out_reg;
        empty_out_next = empty_out_reg;
        ovf_out_next   = ovf_out_reg;

        link_we    = 1'b0;
        link_waddr = cnt_reg[ADDR_W-1:0];
        link_wdata = cnt_inc[ADDR_W-1:0];
        link_raddr = link_rdata;
        tag_we     = 1'b0;
        tag_waddr  = cnt_reg[ADDR_W-1:0];
        tag_raddr  = link_rdata;

        // config write
        if (cfg_valid)
        begin
            skip_next = cfg_data;
        end

        // result taken
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (op == jsurv_pkg::OP_ADD))
                begin
                    // append tag and link to the following slot
                    if (cnt_reg < CNT_MAX)
                    begin
                        tag_we   = 1'b1;
                        link_we  = 1'b1;
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (in_fire)
                begin
                    if (cnt_reg == '0)
                    begin
                        // empty ring answers at once
                        out_valid_next = 1'b1;
                        tag_out_next   = '0;
                        empty_out_next = 1'b1;
                        ovf_out_next   = ovf_reg;
                        ovf_next       = 1'b0;
                    end
                    else
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end

            S_CLOSE:
            begin
                // last person links back to the first
                link_we     = 1'b1;
                link_waddr  = cnt_dec[ADDR_W-1:0];
                link_wdata  = '0;
                link_raddr  = '0;
                tag_raddr   = '0;
                cur_next    = '0;
                prev_next   = '0;
                steps_next  = '0;
                remain_next = cnt_reg;
                if (cnt_reg == CNT_ONE)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // link_rdata holds the successor of cur_reg
                cur_next = link_rdata;
                if (steps_reg != k_eff)
                begin
                    prev_next  = cur_reg;
                    steps_next = steps_reg + SKIP_W'(1);
                end
                else
                begin
                    // unlink cur_reg
                    link_we     = 1'b1;
                    link_waddr  = prev_reg;
                    link_wdata  = link_rdata;
                    steps_next  = '0;
                    remain_next = remain_reg - CNT_ONE;
                    if (remain_reg == CNT_TWO)
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_OUT:
            begin
                out_valid_next = 1'b1;
                tag_out_next   = tag_rdata;
                empty_out_next = 1'b0;
                ovf_out_next   = ovf_reg;
                cnt_next       = '0;
                ovf_next       = 1'b0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            remain_reg    <= '0;
            steps_reg     <= '0;
            skip_reg      <= jsurv_pkg::SKIP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            remain_reg    <= remain_next;
            steps_reg     <= steps_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk pointers and result payload
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        tag_out_reg   <= tag_out_next;
        empty_out_reg <= empty_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    // checks
    `JS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX, "loaded count beyond capacity")
    `JS_ASSERT_IMP(a_walk_remain, state_reg == S_WALK, remain_reg >= CNT_TWO,
        "walk with fewer than two persons")
    `JS_ASSERT_IMP(a_walk_steps, state_reg == S_WALK, steps_reg <= k_eff,
        "step count passed skip")
    `JS_ASSERT_IMP(a_out_free, state_reg == S_OUT, !out_valid_reg,
        "result register busy at end of run")
    `JS_ASSERT_NEXT(a_run_clears, state_reg == S_OUT, (cnt_reg == '0) && !ovf_reg,
        "ring not cleared after run")

endmodule

`default_nettype wire
